// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file sdlcg_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is low.
`define CHK_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication.
`define CHK_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");

// Implication after a fixed number of cycles.
`define CHK_DLY(lbl, clk, rstn, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##dly (cons)) \
        else $error("check failed");

`endif

// ----- sv/sdlcg_pkg.sv -----
// ---------------------------------------------------------------------------
// sdlcg_pkg
// Constants, types and modular helpers for the shuffled dual LCG generator.
// ---------------------------------------------------------------------------
package sdlcg_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int VAL_W         = 31;
    localparam int MUL_W         = 16;
    localparam int PROD_W        = VAL_W + MUL_W;
    localparam int FOLD_W        = 8;

    localparam logic [VAL_W-1:0] MOD_A = 31'd2147483563;
    localparam logic [VAL_W-1:0] MOD_B = 31'd2147483399;
    localparam logic [MUL_W-1:0] MUL_A = 16'd40014;
    localparam logic [MUL_W-1:0] MUL_B = 16'd40692;

    // 2^31 is congruent to these values modulo each modulus
    localparam logic [FOLD_W-1:0] FOLD_A = FOLD_W'(32'h8000_0000 - 32'(MOD_A));
    localparam logic [FOLD_W-1:0] FOLD_B = FOLD_W'(32'h8000_0000 - 32'(MOD_B));

    localparam logic [VAL_W-1:0] RST_X     = 31'd1;
    localparam logic [VAL_W-1:0] RST_Y     = 31'd123456789;
    localparam logic [VAL_W-1:0] WRAP_SPAN = MOD_A - 31'd1;

    // warm-up: TABLE_ENTRIES + 8 steps of the first generator
    localparam int WARM_STEPS = TABLE_ENTRIES + 8;
    localparam int CNT_W      = $clog2(WARM_STEPS);

    // slot = last / SLOT_DIV via reciprocal multiply plus one correction
    localparam longint SLOT_DIV   = 64'd1 + (64'd2147483562 / TABLE_ENTRIES);
    localparam int     SLOT_SHIFT = 40;
    localparam longint SLOT_MUL   = (longint'(1) << SLOT_SHIFT) / SLOT_DIV;
    localparam int     SMUL_W     = $clog2(SLOT_MUL + 1);
    localparam int     PQ_W       = VAL_W + SMUL_W;
    localparam int     Q_W        = IDX_W + 1;
    localparam int     LIM_W      = Q_W + VAL_W;

    typedef struct packed {
        logic seed_load;
        logic mul;
        logic warm_red;
        logic draw_red;
        logic draw_out;
    } t_cmd;

    typedef struct packed {
        logic warm_last;
        logic out_free;
    } t_sts;

    // Reduce a 47-bit product modulo 2^31 - c
    function automatic logic [VAL_W-1:0] mod_fold(input logic [PROD_W-1:0] p,
                                                 input logic [VAL_W-1:0]  m,
                                                 input logic [FOLD_W-1:0] c);
        logic [MUL_W+FOLD_W-1:0] f;
        logic [VAL_W:0]          t;
        f = (MUL_W+FOLD_W)'(p[PROD_W-1:VAL_W]) * (MUL_W+FOLD_W)'(c);
        t = {1'b0, p[VAL_W-1:0]} + (VAL_W+1)'(f);
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[VAL_W-1:0];
    endfunction

endpackage

// ----- sv/sdlcg_ctrl.sv -----
// ---------------------------------------------------------------------------
// sdlcg_ctrl
// Sequencer: accepts beats, runs the warm-up loop and the draw steps.
// ---------------------------------------------------------------------------
module sdlcg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_kind,
    input  sdlcg_pkg::t_sts   i_sts,
    output sdlcg_pkg::t_cmd   o_cmd,
    output logic              o_stall
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WMUL = 3'd1;
    localparam logic [2:0] S_WRED = 3'd2;
    localparam logic [2:0] S_DMUL = 3'd3;
    localparam logic [2:0] S_DRED = 3'd4;
    localparam logic [2:0] S_DOUT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign accept  = (r_state == S_IDLE) && i_valid;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.seed_load = accept && i_kind;
        o_cmd.mul       = (r_state == S_WMUL) || (r_state == S_DMUL);
        o_cmd.warm_red  = (r_state == S_WRED);
        o_cmd.draw_red  = (r_state == S_DRED);
        o_cmd.draw_out  = (r_state == S_DOUT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_kind ? S_WMUL : S_DMUL;
                end
            end
            S_WMUL: n_state = S_WRED;
            S_WRED: n_state = i_sts.warm_last ? S_DMUL : S_WMUL;
            S_DMUL: n_state = S_DRED;
            S_DRED: n_state = S_DOUT;
            S_DOUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/sdlcg_dp.sv -----
// ---------------------------------------------------------------------------
// sdlcg_dp
// Datapath: both generators, shuffle table, slot index and output register.
// ---------------------------------------------------------------------------
module sdlcg_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sdlcg_pkg::t_cmd               i_cmd,
    input  logic [sdlcg_pkg::VAL_W-1:0]   i_seed,
    input  logic                          i_stall,
    output sdlcg_pkg::t_sts               o_sts,
    output logic                          o_valid,
    output logic [sdlcg_pkg::VAL_W-1:0]   o_value
);

    logic [sdlcg_pkg::VAL_W-1:0]  r_x;
    logic [sdlcg_pkg::VAL_W-1:0]  r_y;
    logic [sdlcg_pkg::VAL_W-1:0]  r_last;
    logic [sdlcg_pkg::CNT_W-1:0]  r_cnt;
    logic                         r_valid;
    logic [sdlcg_pkg::VAL_W-1:0]  r_value;

    logic [sdlcg_pkg::PROD_W-1:0] r_px;
    logic [sdlcg_pkg::PROD_W-1:0] r_py;
    logic [sdlcg_pkg::PQ_W-1:0]   r_pq;
    logic [sdlcg_pkg::IDX_W-1:0]  r_slot;
    logic [sdlcg_pkg::VAL_W-1:0]  r_rd;
    logic                         r_rd_vld;

    logic [sdlcg_pkg::VAL_W-1:0]  r_mem [sdlcg_pkg::TABLE_ENTRIES];
    logic [sdlcg_pkg::TABLE_ENTRIES-1:0] r_vld;

    logic [sdlcg_pkg::VAL_W-1:0]  seed_eff;
    logic [sdlcg_pkg::VAL_W-1:0]  x_red;
    logic [sdlcg_pkg::VAL_W-1:0]  y_red;
    logic [sdlcg_pkg::Q_W-1:0]    q_est;
    logic [sdlcg_pkg::Q_W-1:0]    q_nxt;
    logic [sdlcg_pkg::Q_W-1:0]    q_fix;
    logic [sdlcg_pkg::LIM_W-1:0]  lim;
    logic [sdlcg_pkg::IDX_W-1:0]  slot_c;
    logic [sdlcg_pkg::VAL_W-1:0]  rd_eff;
    logic [sdlcg_pkg::VAL_W:0]    diff;
    logic                         warm_wr;
    logic                         wr_en;
    logic [sdlcg_pkg::IDX_W-1:0]  wr_addr;
    logic [sdlcg_pkg::VAL_W-1:0]  wr_data;

    assign seed_eff = (i_seed == '0) ? sdlcg_pkg::VAL_W'(1) : i_seed;
    assign x_red    = sdlcg_pkg::mod_fold(r_px, sdlcg_pkg::MOD_A, sdlcg_pkg::FOLD_A);
    assign y_red    = sdlcg_pkg::mod_fold(r_py, sdlcg_pkg::MOD_B, sdlcg_pkg::FOLD_B);

    // estimate is never high and at most one low
    always_comb begin
        q_est = sdlcg_pkg::Q_W'(r_pq >> sdlcg_pkg::SLOT_SHIFT);
        q_nxt = q_est + sdlcg_pkg::Q_W'(1);
        lim   = sdlcg_pkg::LIM_W'(q_nxt) * sdlcg_pkg::LIM_W'(sdlcg_pkg::SLOT_DIV);
        q_fix = (sdlcg_pkg::LIM_W'(r_last) >= lim) ? q_nxt : q_est;
        if (q_fix >= sdlcg_pkg::Q_W'(sdlcg_pkg::TABLE_ENTRIES)) begin
            slot_c = sdlcg_pkg::IDX_W'(sdlcg_pkg::TABLE_ENTRIES - 1);
        end else begin
            slot_c = q_fix[sdlcg_pkg::IDX_W-1:0];
        end
    end

    // unwritten slots read as zero
    always_comb begin
        rd_eff = r_rd_vld ? r_rd : '0;
        diff   = {1'b0, rd_eff} - {1'b0, r_y};
        if (diff[sdlcg_pkg::VAL_W] || (diff == '0)) begin
            diff = diff + {1'b0, sdlcg_pkg::WRAP_SPAN};
        end
    end

    assign warm_wr = (r_cnt < sdlcg_pkg::CNT_W'(sdlcg_pkg::TABLE_ENTRIES));
    assign wr_en   = (i_cmd.warm_red && warm_wr) || i_cmd.draw_out;
    assign wr_addr = i_cmd.draw_out ? r_slot : r_cnt[sdlcg_pkg::IDX_W-1:0];
    assign wr_data = i_cmd.draw_out ? r_x : x_red;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.draw_red) begin
            r_rd <= r_mem[slot_c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_px <= sdlcg_pkg::PROD_W'(r_x) * sdlcg_pkg::PROD_W'(sdlcg_pkg::MUL_A);
            r_py <= sdlcg_pkg::PROD_W'(r_y) * sdlcg_pkg::PROD_W'(sdlcg_pkg::MUL_B);
            r_pq <= sdlcg_pkg::PQ_W'(r_last) * sdlcg_pkg::PQ_W'(sdlcg_pkg::SLOT_MUL);
        end
        if (i_cmd.draw_red) begin
            r_slot <= slot_c;
        end
        if (i_cmd.draw_out) begin
            r_value <= diff[sdlcg_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= sdlcg_pkg::RST_X;
            r_y      <= sdlcg_pkg::RST_Y;
            r_last   <= '0;
            r_cnt    <= '0;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cmd.seed_load) begin
                r_x   <= seed_eff;
                r_y   <= seed_eff;
                r_cnt <= sdlcg_pkg::CNT_W'(sdlcg_pkg::WARM_STEPS - 1);
            end
            if (i_cmd.warm_red) begin
                r_x   <= x_red;
                r_cnt <= r_cnt - sdlcg_pkg::CNT_W'(1);
                if (r_cnt == '0) begin
                    r_last <= x_red;
                end
            end
            if (i_cmd.draw_red) begin
                r_x      <= x_red;
                r_y      <= y_red;
                r_rd_vld <= r_vld[slot_c];
            end
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.draw_out) begin
                r_last  <= diff[sdlcg_pkg::VAL_W-1:0];
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_sts.warm_last = (r_cnt == '0);
    assign o_sts.out_free  = !r_valid || !i_stall;
    assign o_valid         = r_valid;
    assign o_value         = r_value;

endmodule

// ----- sv/shuffled_dual_lcg_uniform_rng_top.sv -----
// ---------------------------------------------------------------------------
// shuffled_dual_lcg_uniform_rng_top
// Combined two-LCG uniform generator with a shuffle table.
// ---------------------------------------------------------------------------
// channel  direction  handshake           payload
// input    in         i_valid / o_stall   i_kind, i_seed
// output   out        o_valid / i_stall   o_value
//
// Draw: after accept the steps are multiply, fold plus slot index and table
// read, and combine into the output register; then the next beat is taken.
// Reseed: 40 warm-up steps, each a multiply and a fold, on top.
// Synchronous reset clears the state; the table reads as zero until written.
// The next beat is taken while a result still waits; a stalled result holds
// the block in its final step.
module shuffled_dual_lcg_uniform_rng_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_kind,
    input  logic [sdlcg_pkg::VAL_W-1:0] i_seed,
    output logic                        o_stall,
    output logic                        o_valid,
    output logic [sdlcg_pkg::VAL_W-1:0] o_value,
    input  logic                        i_stall
);

    sdlcg_pkg::t_cmd cmd;
    sdlcg_pkg::t_sts sts;

    sdlcg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    sdlcg_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_seed  (i_seed),
        .i_stall (i_stall),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_value (o_value)
    );

endmodule

// ----- sv/sdlcg_chk.sv -----
// ---------------------------------------------------------------------------
// sdlcg_chk
// Port-level checks for the generator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sdlcg_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        i_kind,
    input logic [sdlcg_pkg::VAL_W-1:0] i_seed,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic [sdlcg_pkg::VAL_W-1:0] o_value,
    input logic                        i_stall
);

    logic draw_idle;

    // a draw taken with nothing pending in the output register
    assign draw_idle = i_valid && !o_stall && !i_kind && !o_valid;

    `CHK_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_value))
    `CHK_IMP(a_range, i_clk, i_rst_n, o_valid, (o_value != '0) && (o_value <= sdlcg_pkg::WRAP_SPAN))
    `CHK_NXT(a_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `CHK_DLY(a_draw_lat, i_clk, i_rst_n, draw_idle, 4, o_valid)

endmodule

bind shuffled_dual_lcg_uniform_rng_top sdlcg_chk u_chk (.*);
